FILE: rtl/hru_pkg.sv
// Shared constants, types and helpers for the half-float to unorm pixel converter.
package hru_pkg;

    localparam int MAX_DEPTH   = 12;
    localparam int HALF_W      = 16;
    localparam int LEVEL_W     = MAX_DEPTH;
    localparam int DEPTH_W     = 4;
    localparam int SIG_W       = 11;
    localparam int PROD_W      = SIG_W + LEVEL_W;
    localparam int SHIFT_W     = 5;
    localparam int CHANNELS    = 4;
    localparam int IN_DATA_W   = CHANNELS * HALF_W;
    localparam int OUT_DATA_W  = CHANNELS * LEVEL_W;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    localparam logic [DEPTH_W-1:0] DEPTH_RESET   = 4'd10;
    // word index of a register, taken from paddr[2]
    localparam logic               REG_BIT_DEPTH = 1'b0;

    localparam logic [4:0] EXP_SPECIAL = 5'd31;
    localparam logic [4:0] EXP_ONE     = 5'd15;
    localparam logic [4:0] EXP_SUBNORM = 5'd0;
    localparam logic [SHIFT_W-1:0] SHIFT_SUBNORM = 5'd24;
    localparam logic [SHIFT_W-1:0] SHIFT_BIAS    = 5'd25;

    // Full scale 2^d - 1 with the depth clamped to 1..MAX_DEPTH
    function automatic logic [LEVEL_W-1:0] full_scale(input logic [DEPTH_W-1:0] depth);
        logic [DEPTH_W-1:0] d;
        d = depth;
        if (d < DEPTH_W'(1)) begin
            d = DEPTH_W'(1);
        end
        if (d > DEPTH_W'(MAX_DEPTH)) begin
            d = DEPTH_W'(MAX_DEPTH);
        end
        return {LEVEL_W{1'b1}} >> (DEPTH_W'(MAX_DEPTH) - d);
    endfunction

endpackage

FILE: rtl/hru_cfg.sv
// Configuration register block: bit depth and the derived full-scale value.
module hru_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [hru_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [hru_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [hru_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output logic [hru_pkg::LEVEL_W-1:0]       o_full_scale
);

    logic [hru_pkg::DEPTH_W-1:0] r_bit_depth;
    logic [hru_pkg::LEVEL_W-1:0] r_full_scale;
    logic                        w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && (paddr[2] == hru_pkg::REG_BIT_DEPTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_depth  <= hru_pkg::DEPTH_RESET;
            r_full_scale <= hru_pkg::full_scale(hru_pkg::DEPTH_RESET);
        end else if (w_wr) begin
            r_bit_depth  <= pwdata[hru_pkg::DEPTH_W-1:0];
            r_full_scale <= hru_pkg::full_scale(pwdata[hru_pkg::DEPTH_W-1:0]);
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == hru_pkg::REG_BIT_DEPTH) begin
            prdata = {{(hru_pkg::APB_DATA_W - hru_pkg::DEPTH_W){1'b0}}, r_bit_depth};
        end
    end

    assign o_full_scale = r_full_scale;

endmodule

FILE: rtl/hru_channel.sv
// One channel: binary16 decode, scale by full scale, clamp and truncate.
module hru_channel (
    input  logic [hru_pkg::HALF_W-1:0]  i_half,
    input  logic [hru_pkg::LEVEL_W-1:0] i_full_scale,
    output logic [hru_pkg::LEVEL_W-1:0] o_level
);

    logic                             w_sign;
    logic [4:0]                       w_exp;
    logic [9:0]                       w_frac;
    logic [hru_pkg::SIG_W-1:0]        w_sig;
    logic [hru_pkg::SHIFT_W-1:0]      w_shift;
    logic [hru_pkg::PROD_W-1:0]       w_prod;
    logic [hru_pkg::PROD_W-1:0]       w_shifted;

    assign w_sign = i_half[15];
    assign w_exp  = i_half[14:10];
    assign w_frac = i_half[9:0];

    // subnormals carry no hidden one and share the scale of exponent 1
    assign w_sig   = {(w_exp != hru_pkg::EXP_SUBNORM), w_frac};
    assign w_shift = (w_exp == hru_pkg::EXP_SUBNORM) ? hru_pkg::SHIFT_SUBNORM
                                                     : hru_pkg::SHIFT_BIAS - w_exp;
    assign w_prod    = hru_pkg::PROD_W'(w_sig) * hru_pkg::PROD_W'(i_full_scale);
    assign w_shifted = w_prod >> w_shift;

    always_comb begin
        if (w_exp == hru_pkg::EXP_SPECIAL) begin
            // only +inf maps to full scale; NaN and -inf give zero
            o_level = (w_frac == 10'd0 && !w_sign) ? i_full_scale : '0;
        end else if (w_sign) begin
            o_level = '0;
        end else if (w_exp >= hru_pkg::EXP_ONE) begin
            o_level = i_full_scale;
        end else begin
            o_level = w_shifted[hru_pkg::LEVEL_W-1:0];
        end
    end

endmodule

FILE: rtl/half_rgba_to_unorm_pixel_top.sv
// Top level: input register, four channel converters, result register, config port.

// Converts one RGBA pixel of four IEEE binary16 values into four unsigned levels
// of bit_depth bits (0..2^bit_depth-1, zero-extended to 12 bits). One pixel is taken
// per clock while the result side is not stalled; a pixel passes the input register,
// then the multiply-shift path into the result register. Negative values, NaN and
// -inf give 0; +inf and values of one or more give full scale. bit_depth (offset 0)
// is clamped to 1..12 and should be written only while the pipeline is empty.
module half_rgba_to_unorm_pixel_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // red_half[15:0], green_half[31:16], blue_half[47:32], alpha_half[63:48]
    input  logic [hru_pkg::IN_DATA_W-1:0]       i_s_tdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // red_level[11:0], green_level[23:12], blue_level[35:24], alpha_level[47:36]
    output logic [hru_pkg::OUT_DATA_W-1:0]      o_m_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [hru_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [hru_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [hru_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);

    logic                               r_in_valid;
    logic [hru_pkg::IN_DATA_W-1:0]      r_in_data;
    logic                               r_out_valid;
    logic [hru_pkg::OUT_DATA_W-1:0]     r_out_data;
    logic [hru_pkg::OUT_DATA_W-1:0]     w_levels;
    logic [hru_pkg::LEVEL_W-1:0]        w_full_scale;
    logic                               w_s1_ready;
    logic                               w_s2_ready;

    hru_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_full_scale (w_full_scale)
    );

    for (genvar k = 0; k < hru_pkg::CHANNELS; k++) begin : g_chan
        hru_channel u_chan (
            .i_half       (r_in_data[k*hru_pkg::HALF_W +: hru_pkg::HALF_W]),
            .i_full_scale (w_full_scale),
            .o_level      (w_levels[k*hru_pkg::LEVEL_W +: hru_pkg::LEVEL_W])
        );
    end

    assign w_s2_ready = !r_out_valid || i_m_tready;
    assign w_s1_ready = !r_in_valid || w_s2_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_s1_ready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (w_s2_ready) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_ready && i_s_tvalid) begin
            r_in_data <= i_s_tdata;
        end
        if (w_s2_ready && r_in_valid) begin
            r_out_data <= w_levels;
        end
    end

    assign o_s_tready = w_s1_ready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

`ifndef SYNTHESIS
    // a pixel held in the input stage is not dropped while the output is blocked
    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_s2_ready) |=> r_in_valid)
        else $error("input stage lost a pixel under backpressure");

    // a moving input stage always lands in the result register
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && w_s2_ready) |=> r_out_valid)
        else $error("converted pixel did not reach the result register");

    // full scale tracks the last bit_depth write
    a_scale_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && pready && paddr[2] == hru_pkg::REG_BIT_DEPTH)
        |=> w_full_scale == hru_pkg::full_scale($past(pwdata[hru_pkg::DEPTH_W-1:0])))
        else $error("full scale does not match written bit depth");

    // full scale is always a nonzero run of ones
    a_scale_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_full_scale[0] && ((w_full_scale & (w_full_scale + 1'b1)) == '0))
        else $error("full scale is not 2^d - 1");
`endif

endmodule

FILE: tb/sv/half_rgba_unorm_checker.sv
// Checker for the half-float to unorm pixel converter: predicts levels, compares results.
`timescale 1ns / 1ps

module half_rgba_unorm_checker
    import hru_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    // red_half[15:0], green_half[31:16], blue_half[47:32], alpha_half[63:48]
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    // red_level[11:0], green_level[23:12], blue_level[35:24], alpha_level[47:36]
    input  logic [OUT_DATA_W-1:0] i_m_tdata,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic                  i_pready,
    input  logic [APB_ADDR_W-1:0] i_paddr,
    input  logic [APB_DATA_W-1:0] i_pwdata,
    output int                    o_mismatches,
    output int                    o_outstanding
);

    typedef struct packed {
        logic [HALF_W-1:0] alpha;
        logic [HALF_W-1:0] blue;
        logic [HALF_W-1:0] green;
        logic [HALF_W-1:0] red;
    } rgba_half_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] alpha;
        logic [LEVEL_W-1:0] blue;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] red;
    } rgba_level_t;

    logic [DEPTH_W-1:0] bit_depth_q;
    rgba_level_t        expected_levels[$];
    rgba_level_t        want;
    rgba_level_t        got;
    int                 new_errs;
    string              chan_name[4] = '{"red", "green", "blue", "alpha"};

    // 2^d - 1, depth clamped to 1..MAX_DEPTH
    function automatic logic [LEVEL_W-1:0] level_max(input logic [DEPTH_W-1:0] depth);
        int d;
        d = depth;
        if (d < 1) begin
            d = 1;
        end
        if (d > MAX_DEPTH) begin
            d = MAX_DEPTH;
        end
        return LEVEL_W'((1 << d) - 1);
    endfunction

    function automatic logic [LEVEL_W-1:0] half_to_level(input logic [HALF_W-1:0] h,
                                                         input logic [LEVEL_W-1:0] m);
        logic         sgn;
        logic [4:0]   ex;
        logic [9:0]   fr;
        logic [22:0]  prod;
        sgn = h[15];
        ex  = h[14:10];
        fr  = h[9:0];
        if (ex == EXP_SPECIAL) begin
            // +inf saturates; NaN and -inf go to zero
            return (fr != 10'd0 || sgn) ? '0 : m;
        end
        if (sgn) begin
            return '0;
        end
        if (ex >= EXP_ONE) begin
            return m;
        end
        if (ex == EXP_SUBNORM) begin
            prod = 23'(fr) * 23'(m);
            return LEVEL_W'(prod >> SHIFT_SUBNORM);
        end
        prod = 23'({1'b1, fr}) * 23'(m);
        return LEVEL_W'(prod >> (SHIFT_BIAS - ex));
    endfunction

    function automatic rgba_level_t pixel_levels(input rgba_half_t px,
                                                 input logic [DEPTH_W-1:0] depth);
        rgba_level_t      lv;
        logic [LEVEL_W-1:0] m;
        m        = level_max(depth);
        lv.red   = half_to_level(px.red, m);
        lv.green = half_to_level(px.green, m);
        lv.blue  = half_to_level(px.blue, m);
        lv.alpha = half_to_level(px.alpha, m);
        return lv;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            bit_depth_q <= DEPTH_RESET;
            expected_levels.delete();
            o_mismatches  <= 0;
            o_outstanding <= 0;
        end else begin
            new_errs = 0;
            if (i_psel && i_penable && i_pwrite && i_pready
                && i_paddr[2] == REG_BIT_DEPTH) begin
                bit_depth_q <= i_pwdata[DEPTH_W-1:0];
            end
            if (i_s_tvalid && i_s_tready) begin
                expected_levels.push_back(pixel_levels(rgba_half_t'(i_s_tdata), bit_depth_q));
            end
            if (i_m_tvalid && i_m_tready) begin
                got = rgba_level_t'(i_m_tdata);
                if (expected_levels.size() == 0) begin
                    $display("%0t: result with no request pending, got %h", $time, got);
                    new_errs++;
                end else begin
                    want = expected_levels.pop_front();
                    for (int c = 0; c < CHANNELS; c++) begin
                        if (want[c*LEVEL_W +: LEVEL_W] !== got[c*LEVEL_W +: LEVEL_W]) begin
                            $display("%0t: %s_level expected %0d, actual %0d", $time,
                                     chan_name[c], want[c*LEVEL_W +: LEVEL_W],
                                     got[c*LEVEL_W +: LEVEL_W]);
                            new_errs++;
                        end
                    end
                end
            end
            o_mismatches  <= o_mismatches + new_errs;
            o_outstanding <= expected_levels.size();
        end
    end

endmodule

FILE: tb/sv/tb_half_rgba_to_unorm_pixel_top.sv
// Testbench top: clock, reset, pixel and config stimulus, verdict.
`timescale 1ns / 1ps

module tb_half_rgba_to_unorm_pixel_top;
    import hru_pkg::*;

    localparam int SEGMENTS     = 12;
    localparam int SEG_REQUESTS = 90;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    int                    mismatches;
    int                    outstanding;
    int                    send_idle_pct;
    int                    recv_idle_pct;

    // zeros, infinities, NaNs, edges of the subnormal and normal ranges, values around one
    logic [HALF_W-1:0] directed_halves[24] = '{
        16'h0000, 16'h8000, 16'h7C00, 16'hFC00,
        16'h7E00, 16'hFE00, 16'h7C01, 16'h7FFF,
        16'h3C00, 16'h3BFF, 16'h0001, 16'h03FF,
        16'h0400, 16'h7BFF, 16'hBC00, 16'h3800,
        16'h3555, 16'hFFFF, 16'h0200, 16'h2E66,
        16'h3A00, 16'h0401, 16'h13FF, 16'hBBFF
    };
    // includes depth 0 and depths above the maximum, which clamp
    logic [DEPTH_W-1:0] depth_plan[SEGMENTS] = '{
        4'd1, 4'd12, 4'd0, 4'd15, 4'd7, 4'd12, 4'd1, 4'd3, 4'd13, 4'd4, 4'd9, 4'd12
    };

    half_rgba_to_unorm_pixel_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    half_rgba_unorm_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #1_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // result side back-pressure
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            m_tready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic logic [HALF_W-1:0] random_half();
        int                pick;
        logic [HALF_W-1:0] h;
        pick = $urandom_range(99);
        h    = HALF_W'($urandom);
        if (pick < 45) begin
            h = {1'b0, 5'($urandom_range(14)), h[9:0]};          // below one
        end else if (pick < 55) begin
            h = {1'b0, 5'($urandom_range(30, 15)), h[9:0]};      // one and above
        end else if (pick < 65) begin
            h = {1'b1, h[14:0]};
        end else if (pick < 75) begin
            h = {h[15], EXP_SPECIAL, ($urandom_range(1) ? 10'd0 : h[9:0])};
        end
        return h;
    endfunction

    // called at a falling edge, returns at the falling edge after the request is taken
    task automatic push_pixel(input logic [IN_DATA_W-1:0] px);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = px;
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        s_tvalid = 1'b0;
        while (outstanding != 0) @(negedge i_clk);
    endtask

    task automatic write_bit_depth(input logic [DEPTH_W-1:0] depth);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {REG_BIT_DEPTH, 2'b00};
        pwdata  = APB_DATA_W'(depth);
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        send_idle_pct = 21;
        recv_idle_pct = 72;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed set at the reset depth, then again with channels rotated
        for (int r = 0; r < 2; r++) begin
            for (int p = 0; p < 6; p++) begin
                push_pixel({directed_halves[4*p + (3 + r) % 4],
                            directed_halves[4*p + (2 + r) % 4],
                            directed_halves[4*p + (1 + r) % 4],
                            directed_halves[4*p + r % 4]});
            end
        end
        drain_results();

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            send_idle_pct = (seg < 4) ? 21 : (seg < 8) ? 72 : 0;
            recv_idle_pct = (seg < 4) ? 72 : (seg < 8) ? 21 : 0;
            write_bit_depth(depth_plan[seg]);
            repeat (SEG_REQUESTS) begin
                push_pixel({random_half(), random_half(), random_half(), random_half()});
            end
            drain_results();
        end

        repeat (8) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/hru_pkg.sv
rtl/hru_cfg.sv
rtl/hru_channel.sv
rtl/half_rgba_to_unorm_pixel_top.sv
tb/sv/half_rgba_unorm_checker.sv
tb/sv/tb_half_rgba_to_unorm_pixel_top.sv
